>>> rtl/core/bdq_pkg.sv
// Shared types, constants and ring helper functions for the bounded deque.
package bdq_pkg;

   localparam int MAX_DEPTH = 1024;
   localparam int AW        = $clog2(MAX_DEPTH);
   localparam int CW        = $clog2(MAX_DEPTH + 1);
   localparam int CFG_W     = 11;
   localparam int WORD_W    = 32;
   localparam int CMP_W     = (CW > CFG_W) ? CW : CFG_W;
   localparam int CAP_RESET = 1024;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_PEEK       = 3'd4;

   localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

   typedef struct packed {
      logic [2:0]               opcode;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic                     accepted;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] rear_value;
      logic [CW-1:0]            entry_count;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   // Outcome of the operation presented to the ring control.
   typedef struct packed {
      logic          ok;
      logic          is_push;
      logic          is_pop;
      logic          was_empty;
      logic [CW-1:0] count_next;
   } ring_step_type;

   // Memory access requested by the ring control.
   typedef struct packed {
      logic          wr_en;
      logic [AW-1:0] wr_addr;
      logic          rd_en;
      logic [AW-1:0] rd_addr;
   } ram_req_type;

   function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx);
      return (idx == AW'(MAX_DEPTH - 1)) ? '0 : idx + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] idx);
      return (idx == '0) ? AW'(MAX_DEPTH - 1) : idx - AW'(1);
   endfunction

   // True when the count has reached the limit clamped into 1 .. MAX_DEPTH.
   function automatic logic limit_hit(input logic [CW-1:0] count,
                                      input logic [CFG_W-1:0] cap);
      logic [CMP_W-1:0] cnt_ext;
      logic [CMP_W-1:0] lim_ext;
      cnt_ext = CMP_W'(count);
      lim_ext = CMP_W'(cap);
      if (lim_ext == '0) lim_ext = CMP_W'(1);
      if (lim_ext > CMP_W'(MAX_DEPTH)) lim_ext = CMP_W'(MAX_DEPTH);
      return cnt_ext >= lim_ext;
   endfunction

endpackage

>>> rtl/core/bdq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/bdq_ring.sv
// Head, tail and count registers of the ring buffer and the memory access they imply.
module bdq_ring import bdq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [2:0]       opcode,
   input  logic [CFG_W-1:0] cap,
   output ring_step_type    step,
   output ram_req_type      ram_req,
   output logic [CW-1:0]    count
);

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic          full;

   assign full = limit_hit(count_ff, cap);

   always_comb begin
      step            = '0;
      step.count_next = count_ff;
      step.was_empty  = (count_ff == '0);
      ram_req         = '0;
      ram_req.wr_addr = head_ff;
      ram_req.rd_addr = head_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      unique case (opcode) inside
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            step.is_push = 1'b1;
            step.ok      = !full;
            if (count_ff == '0) begin
               tail_in         = head_ff;
               ram_req.wr_addr = head_ff;
            end else if (opcode == OP_PUSH_FRONT) begin
               head_in         = ring_dec(head_ff);
               ram_req.wr_addr = ring_dec(head_ff);
            end else begin
               tail_in         = ring_inc(tail_ff);
               ram_req.wr_addr = ring_inc(tail_ff);
            end
            step.count_next = count_ff + CW'(1);
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            step.is_pop = 1'b1;
            step.ok     = (count_ff != '0);
            if (count_ff > CW'(1)) begin
               if (opcode == OP_POP_FRONT) begin
                  head_in         = ring_inc(head_ff);
                  ram_req.rd_addr = ring_inc(head_ff);
               end else begin
                  tail_in         = ring_dec(tail_ff);
                  ram_req.rd_addr = ring_dec(tail_ff);
               end
            end
            step.count_next = count_ff - CW'(1);
         end
         OP_PEEK: begin
            step.ok = 1'b1;
         end
         default: begin
            step.ok = 1'b0;
         end
      endcase
      if (!step.ok || (!step.is_push && !step.is_pop)) begin
         step.count_next = count_ff;
         head_in         = head_ff;
         tail_in         = tail_ff;
      end
      ram_req.wr_en = accept && step.ok && step.is_push;
      ram_req.rd_en = accept && step.ok && step.is_pop;
      count_in      = accept ? step.count_next : count_ff;
      if (!accept) begin
         head_in = head_ff;
         tail_in = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

>>> rtl/core/bounded_double_ended_queue.sv
// Pushes, peeks and refused operations give their result in the cycle after acceptance;
// an accepted pop's result passes the entry-store read register, then the result register.
// Pushes and peeks are taken at one transaction per cycle unless the result port stalls;
// a pop holds off new transactions until the registered read of the entry store is back.
// Reset (synchronous, active high) empties the queue and sets the limit to 1024; the entry
// store is not cleared, since only held entries are ever read.
module bounded_double_ended_queue import bdq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   // Controller states: waiting for a transaction, or waiting for a pop's memory read.
   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic                     state_ff, state_in;
   logic                     pop_front_ff, pop_front_in;
   logic signed [WORD_W-1:0] front_ff, front_in;
   logic signed [WORD_W-1:0] rear_ff, rear_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic [CFG_W-1:0]         cap_ff, cap_in;

   logic                     accept;
   logic                     load;
   logic                     res_ok;
   logic signed [WORD_W-1:0] res_front;
   logic signed [WORD_W-1:0] res_rear;
   logic [CW-1:0]            res_count;
   ring_step_type            step;
   ram_req_type              ram_req;
   logic [CW-1:0]            ring_count;
   logic [WORD_W-1:0]        ram_rd_data;

   // A new transaction is taken only when the controller is idle and the result register
   // is empty or is being emptied in this same cycle.
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // User must change the limit only while idle (not enforced); writes are always taken.
   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_data : cap_ff;

   bdq_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .opcode  (req_data.opcode),
      .cap     (cap_ff),
      .step    (step),
      .ram_req (ram_req),
      .count   (ring_count)
   );

   // The entry store holds every queued word; front and rear words are also cached in
   // registers so that only a pop needs to read the memory.
   bdq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (req_data.push_value),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      pop_front_in = pop_front_ff;
      front_in     = front_ff;
      rear_in      = rear_ff;
      load         = 1'b0;
      res_ok       = 1'b0;
      res_count    = ring_count;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (step.ok && step.is_pop) begin
                  // The new end word comes back from memory in the next cycle.
                  state_in     = S_READ;
                  pop_front_in = (req_data.opcode == OP_POP_FRONT);
               end else begin
                  load      = 1'b1;
                  res_ok    = step.ok;
                  res_count = step.count_next;
                  if (step.ok && step.is_push) begin
                     if (step.was_empty) begin
                        front_in = req_data.push_value;
                        rear_in  = req_data.push_value;
                     end else if (req_data.opcode == OP_PUSH_FRONT) begin
                        front_in = req_data.push_value;
                     end else begin
                        rear_in = req_data.push_value;
                     end
                  end
               end
            end
         end
         S_READ: begin
            // The count has already been updated by the pop.
            load   = 1'b1;
            res_ok = 1'b1;
            if (pop_front_ff) begin
               front_in = ram_rd_data;
            end else begin
               rear_in = ram_rd_data;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res_front = (res_count == '0) ? EMPTY_WORD : front_in;
   assign res_rear  = (res_count == '0) ? EMPTY_WORD : rear_in;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.accepted    = res_ok;
         rsp_data_in.front_value = res_front;
         rsp_data_in.rear_value  = res_rear;
         rsp_data_in.entry_count = res_count;
         rsp_data_in.is_empty    = (res_count == '0);
         rsp_data_in.is_full     = limit_hit(res_count, cap_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CFG_W'(CAP_RESET);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_front_ff <= pop_front_in;
      front_ff     <= front_in;
      rear_ff      <= rear_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/bdq_checker.sv
// Port-level assertions for the bounded deque and the bind that attaches them.
module bdq_checker import bdq_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rsp_type          rsp_data
);

   // A stalled result transaction holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.is_empty == (rsp_data.entry_count == '0))
      else $error("empty flag disagrees with count");

   a_empty_words: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |->
         rsp_data.front_value == EMPTY_WORD && rsp_data.rear_value == EMPTY_WORD)
      else $error("empty queue reports stored words");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= CW'(MAX_DEPTH))
      else $error("count beyond depth");

   // With one entry held, front and rear are the same word.
   a_single_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_count == CW'(1) |->
         rsp_data.front_value == rsp_data.rear_value)
      else $error("single entry reports different ends");

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (.*);

>>> dv/tb_top.sv
// Self-checking testbench for the bounded deque: directed and random operations and limits.
`timescale 1ns / 1ps

module tb_top;
   import bdq_pkg::*;

   // Opcodes that the block must ignore.
   localparam logic [2:0] OP_SPARE_A = 3'd5;
   localparam logic [2:0] OP_SPARE_B = 3'd6;
   localparam logic [2:0] OP_SPARE_C = 3'd7;

   // Cycles to let pass after the last result before the block counts as idle.
   localparam int SETTLE_CYCLES = 6;
   // Watchdog limit; the slowest correct run leaves a wide margin below it.
   localparam int CYCLE_LIMIT   = 400000;

   // One pending operation together with the idle cycles that follow it.
   typedef struct packed {
      req_type    op;
      logic [3:0] gap;
   } deque_op_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data  = '0;

   // Operations waiting to be driven and the queue status each accepted one must produce.
   deque_op_type op_backlog[$];
   rsp_type      status_due[$];

   // Shadow copy of the deque: ring contents, both end pointers, fill level and limit.
   logic signed [WORD_W-1:0] ring_words [MAX_DEPTH];
   logic [AW-1:0]            front_idx = '0;
   logic [AW-1:0]            back_idx  = '0;
   int unsigned              held      = 0;
   logic [CFG_W-1:0]         cap_reg   = CFG_W'(CAP_RESET);

   // When set, neither side inserts idle cycles.
   logic         calm = 1'b0;
   int unsigned  idle_left = 0;
   int unsigned  hold_left = 0;
   deque_op_type next_op;
   rsp_type      want;

   int unsigned cycle_count    = 0;
   int unsigned ops_sent       = 0;
   int unsigned results_seen   = 0;
   int unsigned refused_seen   = 0;
   int unsigned full_seen      = 0;
   int unsigned limits_written = 0;
   int unsigned mismatches     = 0;

   bounded_double_ended_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // Applies one operation to the shadow deque and returns the status the block should report.
   // A limit of zero behaves as one, and anything above the ring size behaves as the ring size.
   function automatic rsp_type deque_apply(input req_type r);
      rsp_type     res;
      int unsigned lim;
      logic        ok;
      lim = (cap_reg == '0) ? 1 : ((cap_reg > MAX_DEPTH) ? MAX_DEPTH : int'(cap_reg));
      ok  = 1'b0;
      case (r.opcode) inside
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (held < lim) begin
               if (held == 0) begin
                  // An empty deque restarts both ends at the current front slot.
                  back_idx = front_idx;
                  ring_words[front_idx] = r.push_value;
               end else if (r.opcode == OP_PUSH_FRONT) begin
                  front_idx = (front_idx == '0) ? AW'(MAX_DEPTH - 1) : front_idx - 1'b1;
                  ring_words[front_idx] = r.push_value;
               end else begin
                  back_idx = (back_idx == AW'(MAX_DEPTH - 1)) ? '0 : back_idx + 1'b1;
                  ring_words[back_idx] = r.push_value;
               end
               held++;
               ok = 1'b1;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (held != 0) begin
               // Removing the last entry leaves both pointers where they are.
               if (held > 1) begin
                  if (r.opcode == OP_POP_FRONT) begin
                     front_idx = (front_idx == AW'(MAX_DEPTH - 1)) ? '0 : front_idx + 1'b1;
                  end else begin
                     back_idx = (back_idx == '0) ? AW'(MAX_DEPTH - 1) : back_idx - 1'b1;
                  end
               end
               held--;
               ok = 1'b1;
            end
         end
         OP_PEEK: begin
            ok = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      res.accepted    = ok;
      res.front_value = (held != 0) ? ring_words[front_idx] : EMPTY_WORD;
      res.rear_value  = (held != 0) ? ring_words[back_idx] : EMPTY_WORD;
      res.entry_count = CW'(held);
      res.is_empty    = (held == 0);
      res.is_full     = (held >= lim);
      return res;
   endfunction

   // Driver: presents backlog entries in order and feeds every accepted transaction
   // to the shadow deque. A stalled transaction is held unchanged until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            status_due.push_back(deque_apply(req_data));
            ops_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (idle_left != 0) begin
               req_valid <= 1'b0;
               idle_left--;
            end else if (op_backlog.size() != 0) begin
               next_op = op_backlog.pop_front();
               req_valid <= 1'b1;
               req_data  <= next_op.op;
               idle_left = next_op.gap;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted status transaction against the oldest prediction, then
   // draws how long to stall before taking the next one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (status_due.size() == 0) begin
               $error("status transaction arrived with no operation outstanding");
               mismatches++;
            end else begin
               want = status_due.pop_front();
               if (!want.accepted) refused_seen++;
               if (want.is_full) full_seen++;
               if (rsp_data.accepted !== want.accepted) begin
                  $error("accepted: expected %0d, got %0d", want.accepted, rsp_data.accepted);
                  mismatches++;
               end
               if (rsp_data.front_value !== want.front_value) begin
                  $error("front_value: expected %0d, got %0d",
                         want.front_value, rsp_data.front_value);
                  mismatches++;
               end
               if (rsp_data.rear_value !== want.rear_value) begin
                  $error("rear_value: expected %0d, got %0d",
                         want.rear_value, rsp_data.rear_value);
                  mismatches++;
               end
               if (rsp_data.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, rsp_data.entry_count);
                  mismatches++;
               end
               if (rsp_data.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_data.is_empty);
                  mismatches++;
               end
               if (rsp_data.is_full !== want.is_full) begin
                  $error("is_full: expected %0d, got %0d", want.is_full, rsp_data.is_full);
                  mismatches++;
               end
            end
            hold_left = calm ? 0 : $urandom_range(0, 9);
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: a hang or a missing status transaction ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Appends one operation to the backlog, with the idle gap that follows it.
   task automatic queue_op(input logic [2:0] code, input logic [WORD_W-1:0] word);
      deque_op_type item;
      item.op.opcode     = code;
      item.op.push_value = word;
      item.gap           = calm ? 4'd0 : 4'($urandom_range(0, 9));
      op_backlog.push_back(item);
   endtask

   // Returns once the backlog is sent, every status has been checked and the block
   // has had time to settle, so the limit register may be rewritten.
   task automatic wait_drained();
      int settle;
      do @(negedge clock);
      while (op_backlog.size() != 0 || req_valid || status_due.size() != 0);
      for (settle = 0; settle < SETTLE_CYCLES; settle++) @(negedge clock);
   endtask

   // Writes the capacity limit through the register port and mirrors it in the shadow.
   task automatic write_limit(input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      cap_reg = value;
      limits_written++;
      @(negedge clock);
   endtask

   // Queues a random blend of pushes, pops, peeks and ignored opcodes. Pushes are slightly
   // more likely than pops so that small limits are reached and refusals happen.
   task automatic random_mix(input int count);
      int               i;
      int unsigned      pick;
      logic [2:0]       code;
      logic [WORD_W-1:0] word;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 22) code = OP_PUSH_FRONT;
         else if (pick < 44) code = OP_PUSH_BACK;
         else if (pick < 63) code = OP_POP_FRONT;
         else if (pick < 82) code = OP_POP_BACK;
         else if (pick < 94) code = OP_PEEK;
         else if (pick < 96) code = OP_SPARE_A;
         else if (pick < 98) code = OP_SPARE_B;
         else code = OP_SPARE_C;
         case ($urandom_range(0, 7))
            0: word = 32'h8000_0000;
            1: word = 32'h7FFF_FFFF;
            default: word = $urandom();
         endcase
         queue_op(code, word);
      end
   endtask

   initial begin
      int phase;
      int k;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed sequence at the reset limit. It starts on an empty deque with a peek,
      // refused pops at both ends and all three ignored opcodes, then pushes the word
      // extremes at both ends, pops down through the last entry, and restarts from empty.
      calm = 1'b1;
      queue_op(OP_PEEK, 32'h0);
      queue_op(OP_POP_FRONT, 32'h0);
      queue_op(OP_POP_BACK, 32'h0);
      queue_op(OP_SPARE_A, 32'h1234_5678);
      queue_op(OP_SPARE_B, 32'h0);
      queue_op(OP_SPARE_C, 32'hFFFF_FFFF);
      queue_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
      queue_op(OP_PUSH_BACK, 32'h8000_0000);
      queue_op(OP_PUSH_FRONT, 32'h0000_0000);
      queue_op(OP_PUSH_BACK, 32'hFFFF_FFFF);
      queue_op(OP_PEEK, 32'h0);
      queue_op(OP_SPARE_A, 32'hDEAD_0001);
      queue_op(OP_POP_FRONT, 32'h0);
      queue_op(OP_POP_BACK, 32'h0);
      queue_op(OP_POP_FRONT, 32'h0);
      queue_op(OP_POP_BACK, 32'h0);
      queue_op(OP_POP_FRONT, 32'h0);
      queue_op(OP_PUSH_BACK, 32'h5555_5555);
      queue_op(OP_PUSH_FRONT, 32'hAAAA_AAAA);
      queue_op(OP_POP_BACK, 32'h0);
      queue_op(OP_POP_FRONT, 32'h0);
      queue_op(OP_PEEK, 32'h0);
      wait_drained();

      // Small limits, including zero which must act as one, then a few random ones.
      // The sender holds off between phases until every status has come back.
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_limit(CFG_W'(1));
            1: write_limit(CFG_W'(0));
            2: write_limit(CFG_W'(2));
            3: write_limit(CFG_W'(3));
            7: write_limit(CFG_W'($urandom_range(0, 2047)));
            default: write_limit(CFG_W'($urandom_range(1, 12)));
         endcase
         calm = ($urandom_range(0, 2) == 0);
         random_mix(25);
         wait_drained();
      end

      // Limit above the ring size, clamped to the full depth: fill the ring from
      // both ends until pushes are refused.
      write_limit(CFG_W'(2047));
      calm = 1'b0;
      for (k = 0; k < 1030; k++) begin
         queue_op(($urandom_range(0, 1) == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom());
      end
      wait_drained();

      // Limit lowered far below the fill level: entries stay, pushes are refused.
      write_limit(CFG_W'(5));
      calm = ($urandom_range(0, 1) == 0);
      random_mix(60);
      wait_drained();

      // Limit set exactly to the ring size while nearly full.
      write_limit(CFG_W'(CAP_RESET));
      calm = 1'b0;
      random_mix(60);
      wait_drained();

      $display("Ran %0d deque operations and checked %0d status transactions.",
               ops_sent, results_seen);
      $display("Saw %0d refused operations, %0d full reports, across %0d limit writes.",
               refused_seen, full_seen, limits_written);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/bdq_pkg.sv
rtl/core/bdq_ram.sv
rtl/core/bdq_ring.sv
rtl/core/bounded_double_ended_queue.sv
rtl/core/bdq_checker.sv
dv/tb_top.sv
